@@ src/assert_macros.svh @@
// assertion macros shared by the receive filter rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication checked at every clock edge out of reset
`define ASSERT_IMPLIES(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) else $error(msg);

`endif

@@ src/adrf_pkg.sv @@
// package of the art-net dmx receive filter: job and result types, codes, constants
// no dependencies
`default_nettype none

package adrf_pkg;

  // input operations
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_CHAN     = 2'd0;
  localparam logic [1:0] KIND_VERDICT  = 2'd1;
  localparam logic [1:0] KIND_ACTIVITY = 2'd2;

  // verdict codes
  localparam logic [2:0] VD_ACCEPTED  = 3'd0;
  localparam logic [2:0] VD_POLL      = 3'd1;
  localparam logic [2:0] VD_SHORT     = 3'd2;
  localparam logic [2:0] VD_BAD_ID    = 3'd3;
  localparam logic [2:0] VD_OTHER_OP  = 3'd4;
  localparam logic [2:0] VD_TRUNCATED = 3'd5;
  localparam logic [2:0] VD_WINDOW    = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_UNIVERSE_FIRST   = 2'd0;
  localparam logic [1:0] REG_UNIVERSE_SPAN    = 2'd1;
  localparam logic [1:0] REG_ACTIVITY_TIMEOUT = 2'd2;

  // protocol constants
  localparam logic [15:0] ARTNET_OP_POLL = 16'h2000;
  localparam logic [15:0] ARTNET_OP_DMX  = 16'h5000;
  localparam int unsigned ID_BYTES  = 7;
  localparam int unsigned MIN_BYTES = 10;
  localparam int unsigned HDR_BYTES = 18;

  // fixed field widths
  localparam int unsigned UNI_W = 16;
  localparam int unsigned IDX_W = 9;
  localparam int unsigned LEN_W = 10;
  localparam int unsigned TMO_W = 32;

  // queue between parser and emitter
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // configuration registers as seen by the parser
  typedef struct packed {
    logic [UNI_W-1:0] universe_first;
    logic [UNI_W-1:0] universe_span;
    logic [TMO_W-1:0] activity_timeout;
  } cfg_t;

  // one parsed item, expands into one or two results
  typedef struct packed {
    logic             is_tick;
    logic             has_chan;
    logic             has_verdict;
    logic [UNI_W-1:0] universe;
    logic [IDX_W-1:0] index;
    logic [7:0]       value;
    logic [2:0]       verdict;
    logic [LEN_W-1:0] length;
    logic             active;
  } job_t;

  // one result item
  typedef struct packed {
    logic [1:0]       kind;
    logic [UNI_W-1:0] universe;
    logic [IDX_W-1:0] index;
    logic [7:0]       value;
    logic [2:0]       verdict;
    logic [LEN_W-1:0] length;
    logic             active;
    logic             last;
  } res_t;

  // expected "Art-Net" id bytes
  function automatic logic [7:0] art_id_byte(input logic [2:0] pos);
    logic [7:0] b;
    begin
      unique case (pos)
        3'd0:    b = 8'h41;
        3'd1:    b = 8'h72;
        3'd2:    b = 8'h74;
        3'd3:    b = 8'h2D;
        3'd4:    b = 8'h4E;
        3'd5:    b = 8'h65;
        3'd6:    b = 8'h74;
        default: b = 8'h00;
      endcase
      return b;
    end
  endfunction

endpackage

`default_nettype wire

@@ src/adrf_front.sv @@
// parser front end: accepts bytes and ticks, tracks header state, builds jobs
// depends on adrf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module adrf_front #(
  parameter int unsigned MAX_DATAGRAM = 530,
  parameter int unsigned MAX_CHANNELS = 512
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire adrf_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  input  wire logic          in_ready,
  input  wire logic          in_op,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_end,
  output logic               push,
  output adrf_pkg::job_t     job
);

  localparam int unsigned POS_W = $clog2(MAX_DATAGRAM + 1);
  localparam int unsigned CMP_W = (POS_W > 10) ? POS_W + 1 : 11;
  localparam int unsigned UW    = adrf_pkg::UNI_W;
  localparam int unsigned LW    = adrf_pkg::LEN_W;
  localparam int unsigned TW    = adrf_pkg::TMO_W;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             id_r, id_nxt;
  logic [15:0]      opc_r, opc_nxt;
  logic [UW-1:0]    uni_r, uni_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic             ever_r, ever_nxt;
  logic [TW-1:0]    age_r, age_nxt;

  logic             accept;
  logic [15:0]      len_hi;
  logic [10:0]      len_sum;
  logic [CMP_W-1:0] cnt_ext;
  logic [2:0]       vd;
  logic             emit_chan;

  // window check with an unwrapped 17-bit top
  function automatic logic in_win(input logic [UW-1:0] u);
    logic [UW:0] top;
    begin
      top = {1'b0, cfg.universe_first} + {1'b0, cfg.universe_span};
      return (u >= cfg.universe_first) && ({1'b0, u} < top);
    end
  endfunction

  // channel index is the byte offset past the header
  function automatic logic [adrf_pkg::IDX_W-1:0] IDX_W_TRUNC(input logic [POS_W-1:0] p);
    logic [CMP_W-1:0] d;
    begin
      d = CMP_W'(p) - CMP_W'(adrf_pkg::HDR_BYTES);
      return d[adrf_pkg::IDX_W-1:0];
    end
  endfunction

  assign accept = in_valid && in_ready;
  assign len_hi = {in_byte, 8'h00};
  assign len_sum = 11'(len_r) + 11'(in_byte);

  // parse step, verdict and activity
  always_comb begin
    pos_nxt   = pos_r;
    id_nxt    = id_r;
    opc_nxt   = opc_r;
    uni_nxt   = uni_r;
    len_nxt   = len_r;
    ever_nxt  = ever_r;
    age_nxt   = age_r;
    emit_chan = 1'b0;
    vd        = adrf_pkg::VD_ACCEPTED;
    cnt_ext   = '0;
    job       = '0;
    push      = 1'b0;

    if (accept && in_op == adrf_pkg::OP_TICK) begin
      // tick: saturating age, report activity
      if (age_r != {TW{1'b1}}) age_nxt = age_r + 1'b1;
      job.is_tick = 1'b1;
      job.active  = ever_r && (age_nxt < cfg.activity_timeout);
      push        = 1'b1;
    end else if (accept) begin
      // header capture and channel pass-through
      if (pos_r < POS_W'(MAX_DATAGRAM)) begin
        if (pos_r < POS_W'(adrf_pkg::ID_BYTES)) begin
          if (in_byte != adrf_pkg::art_id_byte(pos_r[2:0])) id_nxt = 1'b0;
        end else if (pos_r == POS_W'(8)) begin
          opc_nxt = {8'h00, in_byte};
        end else if (pos_r == POS_W'(9)) begin
          opc_nxt = {in_byte, opc_r[7:0]};
        end else if (pos_r == POS_W'(14)) begin
          uni_nxt = {8'h00, in_byte};
        end else if (pos_r == POS_W'(15)) begin
          uni_nxt = {in_byte, uni_r[7:0]};
        end else if (pos_r == POS_W'(16)) begin
          len_nxt = (len_hi > 16'(MAX_CHANNELS)) ? LW'(MAX_CHANNELS) : len_hi[LW-1:0];
        end else if (pos_r == POS_W'(17)) begin
          len_nxt = (len_sum > 11'(MAX_CHANNELS)) ? LW'(MAX_CHANNELS) : len_sum[LW-1:0];
        end else if (pos_r >= POS_W'(adrf_pkg::HDR_BYTES)) begin
          emit_chan = id_r && (opc_r == adrf_pkg::ARTNET_OP_DMX) && in_win(uni_r) &&
                      (CMP_W'(pos_r) < CMP_W'(adrf_pkg::HDR_BYTES) + CMP_W'(len_r));
        end
        pos_nxt = pos_r + 1'b1;
      end

      job.has_chan = emit_chan;
      job.universe = uni_nxt;
      job.index    = IDX_W_TRUNC(pos_r);
      job.value    = in_byte;
      job.length   = len_nxt;

      // end of datagram: verdict from the updated header state
      if (in_end) begin
        cnt_ext = CMP_W'(pos_nxt);
        if (cnt_ext < CMP_W'(adrf_pkg::MIN_BYTES)) vd = adrf_pkg::VD_SHORT;
        else if (!id_nxt) vd = adrf_pkg::VD_BAD_ID;
        else if (opc_nxt == adrf_pkg::ARTNET_OP_POLL) vd = adrf_pkg::VD_POLL;
        else if (opc_nxt != adrf_pkg::ARTNET_OP_DMX) vd = adrf_pkg::VD_OTHER_OP;
        else if (cnt_ext < CMP_W'(adrf_pkg::HDR_BYTES) + CMP_W'(len_nxt))
          vd = adrf_pkg::VD_TRUNCATED;
        else if (!in_win(uni_nxt)) vd = adrf_pkg::VD_WINDOW;
        else vd = adrf_pkg::VD_ACCEPTED;

        if (vd == adrf_pkg::VD_ACCEPTED) begin
          ever_nxt = 1'b1;
          age_nxt  = '0;
        end
        job.has_verdict = 1'b1;
        job.verdict     = vd;

        pos_nxt = '0;
        id_nxt  = 1'b1;
        opc_nxt = '0;
        uni_nxt = '0;
        len_nxt = '0;
      end
      push = emit_chan || in_end;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      id_r   <= 1'b1;
      opc_r  <= '0;
      uni_r  <= '0;
      len_r  <= '0;
      ever_r <= 1'b0;
      age_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      id_r   <= id_nxt;
      opc_r  <= opc_nxt;
      uni_r  <= uni_nxt;
      len_r  <= len_nxt;
      ever_r <= ever_nxt;
      age_r  <= age_nxt;
    end
  end

  // byte count never passes the datagram limit
  `ASSERT_HOLDS(a_pos_sat, pos_r <= POS_W'(MAX_DATAGRAM), "byte position past datagram limit")

endmodule

`default_nettype wire

@@ src/adrf_queue.sv @@
// short job queue between parser and result emitter
// depends on adrf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module adrf_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire adrf_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output adrf_pkg::job_t      head
);

  adrf_pkg::job_t                   slot_r [adrf_pkg::QUEUE_DEPTH];
  logic [adrf_pkg::QPTR_W-1:0]      wr_r, wr_nxt;
  logic [adrf_pkg::QPTR_W-1:0]      rd_r, rd_nxt;
  logic [adrf_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                             do_push, do_pop;

  assign full    = (cnt_r == adrf_pkg::QCNT_W'(adrf_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = slot_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointer and fill count
  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + adrf_pkg::QCNT_W'(do_push) - adrf_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_r] <= push_job;
  end

  `ASSERT_HOLDS(a_cnt_bound, cnt_r <= adrf_pkg::QCNT_W'(adrf_pkg::QUEUE_DEPTH), "queue overfilled")
  `ASSERT_IMPLIES(a_no_push_full, push, !full, "job pushed into a full queue")

endmodule

`default_nettype wire

@@ src/adrf_back.sv @@
// result emitter: expands queued jobs into result items behind an output register
// depends on adrf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module adrf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire adrf_pkg::job_t head,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output adrf_pkg::res_t      out_res
);

  logic           valid_r, valid_nxt;
  logic           phase_r, phase_nxt;
  adrf_pkg::res_t res_r, res_nxt;
  logic           load;

  assign load      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // pick the next result of the head job
  always_comb begin
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    res_nxt   = res_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        res_nxt = '0;
        if (head.is_tick) begin
          res_nxt.kind   = adrf_pkg::KIND_ACTIVITY;
          res_nxt.active = head.active;
          res_nxt.last   = 1'b1;
          pop            = 1'b1;
        end else if (head.has_chan && !phase_r) begin
          res_nxt.kind     = adrf_pkg::KIND_CHAN;
          res_nxt.universe = head.universe;
          res_nxt.index    = head.index;
          res_nxt.value    = head.value;
          res_nxt.length   = head.length;
          res_nxt.last     = !head.has_verdict;
          phase_nxt        = head.has_verdict;
          pop              = !head.has_verdict;
        end else begin
          res_nxt.kind     = adrf_pkg::KIND_VERDICT;
          res_nxt.universe = head.universe;
          res_nxt.verdict  = head.verdict;
          res_nxt.length   = head.length;
          res_nxt.last     = 1'b1;
          phase_nxt        = 1'b0;
          pop              = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // a pending verdict always sits at the head of the queue
  `ASSERT_IMPLIES(a_phase_head, phase_r, !q_empty && head.has_verdict && !head.is_tick,
                  "second result pending without its job")

endmodule

`default_nettype wire

@@ src/artnet_dmx_receive_filter.sv @@
// Art-Net ArtDmx receive filter, top level: config registers, parser, queue, emitter
// depends on adrf_pkg, adrf_front, adrf_queue, adrf_back
//
// Usage:
//   in_*  : one item per handshake; in_tuser = 0 carries a UDP payload byte in
//           in_tdata with in_tlast marking the last byte of a datagram,
//           in_tuser = 1 is a time tick.
//   out_* : results; a channel byte for ArtDmx packets in the universe window,
//           a verdict at each datagram end, an activity flag for each tick.
//           out_tlast marks the last result caused by one input item.
//   cfg_* : register writes (index 0 first universe, 1 span, 2 timeout), always
//           ready, to be done while the block is idle.
// Flow: the queue is written at the edge that accepts an item, and the emitter
//   registers the first result of the item in the output register when the
//   register is free or being read and older queued jobs have gone out.
// Throughput: one item per cycle while in_tready is high; a final byte that
//   also yields a channel result gives two results, absorbed by the 4-entry queue.
// Reset: parse state and activity age clear, registers take their defaults.
// A stalled receiver holds the output register; the queue fills and in_tready
// drops only when all four entries are taken.
`default_nettype none

module artnet_dmx_receive_filter #(
  parameter int unsigned MAX_DATAGRAM = 530,
  parameter int unsigned MAX_CHANNELS = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] payload_byte
  input  wire logic        in_tuser,   // [0] operation
  input  wire logic        in_tlast,   // end_of_datagram
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] dmx_universe, [24:16] channel_index, [32:25] channel_value,
  // [35:33] verdict, [45:36] data_length, [46] input_active, [47] zero
  output logic [47:0]      out_tdata,
  output logic [1:0]       out_tuser,  // [1:0] result_kind
  output logic             out_tlast,  // last_of_run
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  adrf_pkg::cfg_t cfg_r, cfg_nxt;
  adrf_pkg::job_t job, head;
  adrf_pkg::res_t res;
  logic           push, pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        adrf_pkg::REG_UNIVERSE_FIRST:   cfg_nxt.universe_first   = cfg_data[15:0];
        adrf_pkg::REG_UNIVERSE_SPAN:    cfg_nxt.universe_span    = cfg_data[15:0];
        adrf_pkg::REG_ACTIVITY_TIMEOUT: cfg_nxt.activity_timeout = cfg_data;
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.universe_first   <= 16'd0;
      cfg_r.universe_span    <= 16'd4;
      cfg_r.activity_timeout <= 32'd1000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = !q_full;

  // parser
  adrf_front #(
    .MAX_DATAGRAM(MAX_DATAGRAM),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser),
    .in_byte  (in_tdata),
    .in_end   (in_tlast),
    .push     (push),
    .job      (job)
  );

  // job queue
  adrf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  // result emitter
  adrf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // pack the result item
  assign out_tdata = {1'b0, res.active, res.length, res.verdict, res.value, res.index,
                      res.universe};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

`default_nettype wire
